FILE: src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES_DEF = 16;

    // capacity register
    localparam int         CAP_W     = 5;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // register map: index is paddr[2]
    localparam int   PADDR_W      = 3;
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;
    localparam logic signed [31:0] PUT_VALUE  = 32'sd0;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // lookup status from the tag array
    typedef struct packed {
        logic hit;
        logic full;
    } lkv_lookup_t;

endpackage

FILE: src/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// Valid/ready channels for cache requests and responses.
// ----------------------------------------------------------------------------
interface lkv_req_if
    import lkv_pkg::*;
;
    logic               valid;
    logic               ready;
    cmd_t               cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

FILE: src/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lkv_tags.sv
// ----------------------------------------------------------------------------
// lkv_tags
// Key lanes with valid bits and recency ranks; parallel match, LRU update.
// ----------------------------------------------------------------------------
module lkv_tags
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd,
    input  cmd_t               cmd,
    input  logic signed [31:0] key,
    input  logic [CAP_W-1:0]   capacity,
    output lkv_lookup_t        lookup,
    output logic [IDX_W-1:0]   hit_idx,
    output logic [IDX_W-1:0]   slot_idx,
    output logic [CNT_W-1:0]   filled
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic signed [31:0] key_reg   [ENTRIES];
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [ENTRIES-1:0] free;
    logic [IDX_W-1:0]   hit_rank;
    logic [IDX_W-1:0]   last_rank;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               full;
    logic               hit;
    logic               insert;

    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full      = (CMP_W'(count_reg) >= eff_cap);
    // ranks of valid entries are a permutation of 0..count-1, so the lru is count-1
    assign last_rank = IDX_W'(count_reg - CNT_W'(1));
    assign insert    = upd && (cmd == CMD_PUT) && !hit;

    always_comb
    begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (key_reg[i] == key);
            victim[i] = full && valid_reg[i] && (rank_reg[i] == last_rank);
            free[i]   = !(valid_reg[i] && !victim[i]);
            if (match[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
        end
        hit = |match;
    end

    // lowest free entry after eviction
    always_comb
    begin
        slot_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (free[i])
            begin
                slot_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (upd && hit)
        begin
            // promote: entries more recent than the hit age by one
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
        end
        else if (insert)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_idx == IDX_W'(i))
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i]  = '0;
                end
                else if (victim[i])
                begin
                    valid_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
            if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (insert && (slot_idx == IDX_W'(i)))
            begin
                key_reg[i] <= key;
            end
        end
    end

    assign lookup.hit  = hit;
    assign lookup.full = full;
    assign filled      = count_reg;

endmodule

FILE: src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  port      dir   protocol     contents
//  req       in    valid/ready  cmd, key, value
//  rsp       out   valid/ready  hit, read_value
//  psel..    in    apb          capacity_in_use at 0x0
//
//  one request per clock while the response is not stalled; a request's
//  response is registered: the key compare, rank update and value ram read
//  run from the request register into the response register.
//  reset clears valid bits, ranks and fill count; no clearing pass.
//  a stalled response holds the pipeline; the request register takes one more
//  transfer only while it is empty.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    lkv_req_if.sink            req,
    lkv_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CAP_W-1:0]   cap_reg;

    logic               stg_valid_reg;
    cmd_t               stg_cmd_reg;
    logic signed [31:0] stg_key_reg;
    logic signed [31:0] stg_value_reg;

    logic               res_valid_reg;
    cmd_t               res_cmd_reg;
    logic               res_hit_reg;

    logic               advance;
    logic               upd;
    lkv_lookup_t        lookup;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   slot_idx;
    logic [CNT_W-1:0]   filled;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_re;
    logic [31:0]        ram_rdata;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_reg} : '0;

    // pipeline control
    assign advance   = !res_valid_reg || rsp.ready;
    assign upd       = stg_valid_reg && advance;
    assign req.ready = !stg_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                stg_valid_reg <= req.valid;
            end
            if (advance)
            begin
                res_valid_reg <= stg_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            stg_cmd_reg   <= req.cmd;
            stg_key_reg   <= req.key;
            stg_value_reg <= req.value;
        end
        if (upd)
        begin
            res_cmd_reg <= stg_cmd_reg;
            res_hit_reg <= lookup.hit;
        end
    end

    lkv_tags #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_tags (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .cmd      (stg_cmd_reg),
        .key      (stg_key_reg),
        .capacity (cap_reg),
        .lookup   (lookup),
        .hit_idx  (hit_idx),
        .slot_idx (slot_idx),
        .filled   (filled)
    );

    // values live in ram; a put writes, a get hit reads
    assign ram_we    = upd && (stg_cmd_reg == CMD_PUT);
    assign ram_waddr = lookup.hit ? hit_idx : slot_idx;
    assign ram_re    = upd && (stg_cmd_reg == CMD_GET) && lookup.hit;

    lkv_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_values (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (stg_value_reg),
        .re    (ram_re),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    assign rsp.valid      = res_valid_reg;
    assign rsp.hit        = res_hit_reg;
    assign rsp.read_value = (res_cmd_reg == CMD_PUT) ? PUT_VALUE :
                            (res_hit_reg ? ram_rdata : MISS_VALUE);

    // checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(ENTRIES) >= filled)
        else $error("fill count above entry count");

    a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && lookup.hit) |=> $stable(filled))
        else $error("fill count changed on a hit");

    a_evict_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && (stg_cmd_reg == CMD_PUT) && !lookup.hit && lookup.full) |=> $stable(filled))
        else $error("fill count changed on an evicting put");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (res_cmd_reg == CMD_GET) && !rsp.hit) |-> (rsp.read_value == MISS_VALUE))
        else $error("get miss without miss value");

endmodule

FILE: verif/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key/value cache. A short table of directed
// gets, puts and capacity writes runs first, then random traffic drawn from
// small key pools so hits, updates and evictions are frequent. Every response
// is checked against a table value or a behavioral copy; back-pressure varies.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
    import lkv_pkg::*;

    localparam int ENTRIES      = ENTRIES_DEF;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEMS_TOTAL  = 2000;
    localparam int PHASES       = 12;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cmd_t        cmd;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;
        logic        exp_hit;
        logic [31:0] exp_value;
    } stim_row_t;

    typedef struct {
        logic        hit;
        logic [31:0] read_value;
    } lookup_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    lru_key_value_cache #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // shadow copy of the cache
    logic [31:0]     cache_keys [ENTRIES];
    logic [31:0]     cache_vals [ENTRIES];
    bit              cache_valid [ENTRIES];
    int              cache_rank [ENTRIES];
    int              fill_count;
    logic [CAP_W-1:0] capacity_reg;

    lookup_result_t  results_due [$];
    stim_row_t       directed_rows [$];
    int              mismatches = 0;
    int              quiet_cycles = 0;
    int              req_idle_pct = 0;
    int              rsp_idle_pct = 0;

    function automatic stim_row_t row_item(cmd_t c, logic [31:0] k, logic [31:0] v);
        row_item = '{ROW_ITEM, c, k, v, 1'b0, 1'b0, 32'h0};
    endfunction

    function automatic stim_row_t row_checked(cmd_t c, logic [31:0] k, logic [31:0] v,
                                              logic h, logic [31:0] rv);
        row_checked = '{ROW_ITEM, c, k, v, 1'b1, h, rv};
    endfunction

    function automatic stim_row_t row_cfg(logic [31:0] v);
        row_cfg = '{ROW_CFG, CMD_GET, 32'h0, v, 1'b0, 1'b0, 32'h0};
    endfunction

    // entries more recent than idx age by one, idx becomes most recent
    function automatic void promote_entry(int idx);
        int r;
        r = cache_rank[idx];
        for (int i = 0; i < ENTRIES; i++)
            if (cache_valid[i] && cache_rank[i] < r)
                cache_rank[i]++;
        cache_rank[idx] = 0;
    endfunction

    function automatic void cache_lookup(input cmd_t cmd, input logic [31:0] key,
                                         input logic [31:0] value,
                                         output lookup_result_t res);
        int found;
        int victim;
        int slot;
        int eff_cap;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && cache_valid[i] && cache_keys[i] == key)
                found = i;
        res.hit = (found >= 0);
        if (cmd == CMD_GET)
        begin
            res.read_value = (found >= 0) ? cache_vals[found] : MISS_VALUE;
            if (found >= 0)
                promote_entry(found);
            return;
        end
        res.read_value = PUT_VALUE;
        if (found >= 0)
        begin
            cache_vals[found] = value;
            promote_entry(found);
            return;
        end
        eff_cap = (capacity_reg == 0) ? 1 :
                  (int'(capacity_reg) > ENTRIES) ? ENTRIES : int'(capacity_reg);
        // evict exactly one lru entry, even when the fill is above capacity
        if (fill_count >= eff_cap)
        begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (cache_valid[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
                    victim = i;
            if (victim >= 0)
            begin
                cache_valid[victim] = 1'b0;
                cache_rank[victim] = 0;
                if (fill_count > 0)
                    fill_count--;
            end
        end
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !cache_valid[i])
                slot = i;
        if (slot >= 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (cache_valid[i])
                    cache_rank[i]++;
            cache_keys[slot] = key;
            cache_vals[slot] = value;
            cache_valid[slot] = 1'b1;
            cache_rank[slot] = 0;
            fill_count++;
        end
    endfunction

    // called right after a falling edge, returns right after one
    task automatic send_request(input stim_row_t r);
        lookup_result_t res;
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= r.cmd;
        req_ch.key   <= r.key;
        req_ch.value <= r.value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        cache_lookup(r.cmd, r.key, r.value, res);
        if (r.typed)
        begin
            res.hit = r.exp_hit;
            res.read_value = r.exp_value;
        end
        results_due.push_back(res);
        @(negedge clk);
    endtask

    // hold the sender off until every response is back and the pipe is empty
    task automatic settle_idle();
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] cap);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * REG_CAPACITY);
        pwdata  <= {27'($urandom_range(0, 32'h07ff_ffff)), cap};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        capacity_reg = cap;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // response side: random back-pressure driven at the falling edge
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, got hit=%0b value=%h",
                         $time, rsp_ch.hit, rsp_ch.read_value);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (rsp_ch.hit !== want.hit)
                begin
                    $display("%0t: hit mismatch, expected %0b, got %0b",
                             $time, want.hit, rsp_ch.hit);
                    mismatches++;
                end
                if (rsp_ch.read_value !== want.read_value)
                begin
                    $display("%0t: read_value mismatch, expected %h, got %h",
                             $time, want.read_value, rsp_ch.read_value);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any port
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("lru_key_value_cache verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] key_pool [24];
        logic [4:0]  cap_choices [12];
        int          pool_size;
        int          per_phase;
        stim_row_t   r;
        logic [31:0] k;

        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_GET;
        req_ch.key   = '0;
        req_ch.value = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_keys[i]  = '0;
            cache_vals[i]  = '0;
            cache_valid[i] = 1'b0;
            cache_rank[i]  = 0;
        end
        fill_count   = 0;
        capacity_reg = CAP_RESET;
        cap_choices  = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd8, 5'd11,
                         5'd15, 5'd16, 5'd17, 5'd31};

        // empty cache, extreme keys and values, update, near-miss key
        directed_rows.push_back(row_checked(CMD_GET, 32'h0000_0000, 32'h0, 1'b0, MISS_VALUE));
        directed_rows.push_back(row_checked(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b0,
                                            PUT_VALUE));
        directed_rows.push_back(row_checked(CMD_GET, 32'h8000_0000, 32'h0, 1'b1, 32'h7fff_ffff));
        directed_rows.push_back(row_checked(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b0,
                                            PUT_VALUE));
        directed_rows.push_back(row_checked(CMD_GET, 32'h7fff_ffff, 32'hffff_ffff, 1'b1,
                                            32'h8000_0000));
        directed_rows.push_back(row_checked(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b0,
                                            PUT_VALUE));
        directed_rows.push_back(row_checked(CMD_GET, 32'hffff_ffff, 32'h0, 1'b1, 32'hffff_ffff));
        directed_rows.push_back(row_checked(CMD_PUT, 32'h8000_0000, 32'h0, 1'b1, PUT_VALUE));
        directed_rows.push_back(row_checked(CMD_GET, 32'h8000_0000, 32'h5a5a_5a5a, 1'b1, 32'h0));
        directed_rows.push_back(row_checked(CMD_GET, 32'h8000_0001, 32'h0, 1'b0, MISS_VALUE));
        directed_rows.push_back(row_checked(CMD_GET, 32'h0000_0000, 32'h0, 1'b0, MISS_VALUE));
        // capacity below current fill: each put miss evicts one lru entry
        directed_rows.push_back(row_cfg(32'd2));
        directed_rows.push_back(row_checked(CMD_PUT, 32'h0000_0005, 32'h55, 1'b0, PUT_VALUE));
        directed_rows.push_back(row_item(CMD_GET, 32'h7fff_ffff, 32'h0));
        directed_rows.push_back(row_item(CMD_PUT, 32'h0000_0006, 32'h66));
        directed_rows.push_back(row_item(CMD_GET, 32'hffff_ffff, 32'h0));
        // zero capacity behaves as one
        directed_rows.push_back(row_cfg(32'd0));
        directed_rows.push_back(row_item(CMD_PUT, 32'h0000_0007, 32'h1));
        directed_rows.push_back(row_item(CMD_PUT, 32'h0000_0008, 32'h2));
        directed_rows.push_back(row_item(CMD_GET, 32'h0000_0007, 32'h0));
        // oversize capacity clamps to the entry count
        directed_rows.push_back(row_cfg(32'hffff_ffff));
        directed_rows.push_back(row_item(CMD_PUT, 32'h0000_0009, 32'h9));
        directed_rows.push_back(row_item(CMD_PUT, 32'h0000_000a, 32'ha));
        directed_rows.push_back(row_item(CMD_GET, 32'h0000_0005, 32'h0));
        directed_rows.push_back(row_item(CMD_PUT, 32'h0000_0000, 32'h1234_5678));
        directed_rows.push_back(row_item(CMD_GET, 32'h0000_0000, 32'h0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                settle_idle();
                write_capacity(directed_rows[i].value[4:0]);
            end
            else
                send_request(directed_rows[i]);
        end

        per_phase = ITEMS_TOTAL / PHASES;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph / (PHASES / 3))
                0: begin req_idle_pct = 12; rsp_idle_pct = 83; end
                1: begin req_idle_pct = 83; rsp_idle_pct = 12; end
                default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
            endcase
            settle_idle();
            write_capacity(cap_choices[$urandom_range(0, 11)]);

            // small key pool so hits and evictions are common
            pool_size = $urandom_range(2, 24);
            for (int i = 0; i < pool_size; i++)
            begin
                case ($urandom_range(0, 7))
                    0: key_pool[i] = 32'h8000_0000;
                    1: key_pool[i] = 32'h7fff_ffff;
                    2: key_pool[i] = 32'hffff_ffff;
                    3: key_pool[i] = 32'h0000_0000;
                    4: key_pool[i] = (i > 0) ?
                           key_pool[$urandom_range(0, i - 1)] ^ (32'h1 << $urandom_range(0, 31)) :
                           $urandom;
                    default: key_pool[i] = $urandom;
                endcase
            end

            for (int n = 0; n < per_phase; n++)
            begin
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, pool_size - 1)];
                else
                    k = $urandom;
                r = row_item(cmd_t'($urandom_range(0, 1)), k, $urandom);
                if ($urandom_range(0, 249) == 0)
                    settle_idle();
                send_request(r);
            end
        end

        settle_idle();
        if (mismatches == 0)
            $display("lru_key_value_cache verification clean");
        else
            $display("lru_key_value_cache verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/lkv_pkg.sv
src/lkv_if.sv
src/lkv_ram.sv
src/lkv_tags.sv
src/lru_key_value_cache.sv
verif/tb_lru_key_value_cache.sv
